/* hw/rtl/g3c_pkg.sv */
// shared constants, types and helpers for the three-point centroid block
package g3c_pkg;
  localparam int MaxDim = 32;
  localparam int PixelBits = 16;
  localparam int StoreDepth = MaxDim * MaxDim;
  localparam int AddrBits = $clog2(StoreDepth);
  localparam int DimBits = $clog2(MaxDim + 1);
  localparam int PosBits = $clog2(MaxDim);
  localparam int CountBits = 11;
  localparam int LogBits = 21;
  localparam int SumBits = PixelBits + 3;

  localparam logic [1:0] RegRows = 2'd0;
  localparam logic [1:0] RegCols = 2'd1;
  localparam logic [1:0] RegFactor = 2'd2;

  typedef struct packed {
    logic [DimBits-1:0] rows;
    logic [DimBits-1:0] cols;
    logic [4:0]         factor;
  } cfg_t;

  typedef struct packed {
    logic [PosBits-1:0] row;
    logic [PosBits-1:0] col;
    logic [3:0]         sub_row;
    logic [3:0]         sub_col;
    logic               gauss_row;
    logic               gauss_col;
    logic               degenerate;
  } result_t;

  function automatic logic [DimBits-1:0] clamp_dim(input logic [5:0] v);
    logic [DimBits-1:0] r;
    if (v == 6'd0) r = DimBits'(1);
    else if (32'(v) > MaxDim) r = DimBits'(MaxDim);
    else r = DimBits'(v);
    return r;
  endfunction

  function automatic logic [4:0] clamp_factor(input logic [4:0] v);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (v > 5'd16) r = 5'd16;
    else r = v;
    return r;
  endfunction
endpackage

/* hw/rtl/g3c_log2.sv */
// iterative fixed-point log2, one squaring per cycle
module g3c_log2 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [g3c_pkg::PixelBits-1:0]   x_i,
  output logic                            done_o,
  output logic [g3c_pkg::LogBits-1:0]     log_o
);
  logic [32:0] m_q, m_d;
  logic [4:0]  exp_q, exp_d;
  logic [15:0] frac_q, frac_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        zero_q, zero_d;
  logic [65:0] sq;
  logic [33:0] shifted;
  logic [4:0]  top;

  always_comb begin
    top = 5'd0;
    for (int i = 0; i < g3c_pkg::PixelBits; i++) begin
      if (x_i[i]) top = 5'(i);
    end
  end

  assign sq = 66'(m_q[31:0]) * 66'(m_q[31:0]);
  assign shifted = 34'(sq >> 31);

  always_comb begin
    m_d = m_q;
    exp_d = exp_q;
    frac_d = frac_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    zero_d = zero_q;
    if (start_i) begin
      m_d = 33'({17'd0, x_i} << (5'd31 - top));
      exp_d = top;
      frac_d = 16'd0;
      cnt_d = 5'd0;
      busy_d = 1'b1;
      zero_d = (x_i == '0);
    end else if (busy_q) begin
      if (shifted[32]) begin
        m_d = shifted[33:1];
        frac_d = {frac_q[14:0], 1'b1};
      end else begin
        m_d = shifted[32:0];
        frac_d = {frac_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    exp_q <= exp_d;
    frac_q <= frac_d;
    zero_q <= zero_d;
  end

  assign done_o = busy_q && (cnt_q == 5'd15);
  assign log_o = zero_d ? '0 : {exp_q, frac_d};
endmodule

/* hw/rtl/g3c_divider.sv */
// restoring divider, one quotient bit per cycle
module g3c_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [31:0] quo_q, den_q;
  logic [32:0] rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;

  assign trial = {rem_q[31:0], quo_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd31) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  // done marks the last step, the quotient is held from the next cycle on
  assign done_o = busy_q && (cnt_q == 6'd31);
  assign quo_o = quo_q;
endmodule

/* hw/rtl/g3c_regs.sv */
// configuration registers behind the apb port
module g3c_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output g3c_pkg::cfg_t cfg_o
);
  logic [5:0] rows_q, cols_q;
  logic [4:0] fac_q;
  logic [1:0] idx;

  assign idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 6'd8;
      cols_q <= 6'd8;
      fac_q <= 5'd4;
    end else if (psel && penable && pwrite) begin
      case (idx)
        g3c_pkg::RegRows: rows_q <= pwdata[5:0];
        g3c_pkg::RegCols: cols_q <= pwdata[5:0];
        g3c_pkg::RegFactor: fac_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      g3c_pkg::RegRows: prdata = {26'd0, rows_q};
      g3c_pkg::RegCols: prdata = {26'd0, cols_q};
      g3c_pkg::RegFactor: prdata = {27'd0, fac_q};
      default: prdata = '0;
    endcase
  end

  assign cfg_o.rows = g3c_pkg::clamp_dim(rows_q);
  assign cfg_o.cols = g3c_pkg::clamp_dim(cols_q);
  assign cfg_o.factor = g3c_pkg::clamp_factor(fac_q);
endmodule

/* hw/rtl/gaussian_three_point_centroid_top.sv */
// top level: patch store, peak tracking and sub-pixel sequencer
//  channel | direction | handshake       | payload
//  pixel   | in        | valid_i/ready_o | pixel_value_i
//  result  | out       | valid_o/ready_i | peak_row_o .. degenerate_o
//  config  | in        | apb             | patch_rows, patch_cols, reduction_factor
// pixels load one per cycle, only in the load state, into a patch memory with a write and a read port;
// peak row and column kept on the fly. after the last pixel: reads of the peak and its four neighbours, a capture,
// then per axis (setup, log2 steps, divider start, divider steps, store) and an output state
// a patch end with a zero peak and zero neighbours skips the axes; until the return to loading no pixel is accepted
// a result not yet taken holds the sequencer in its output state at the next patch end
// reset clears counters and the peak; the memory needs no clearing
module gaussian_three_point_centroid_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] pixel_value_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [4:0]  peak_row_o,
  output logic [4:0]  peak_col_o,
  output logic [3:0]  sub_row_o,
  output logic [3:0]  sub_col_o,
  output logic        row_used_gaussian_o,
  output logic        col_used_gaussian_o,
  output logic        degenerate_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [10:0] {
    StLoad  = 11'b00000000001,
    StRead  = 11'b00000000010,
    StCap   = 11'b00000000100,
    StAxis  = 11'b00000001000,
    StLog   = 11'b00000010000,
    StLogW  = 11'b00000100000,
    StDivS  = 11'b00001000000,
    StDivW  = 11'b00010000000,
    StNext  = 11'b00100000000,
    StOut   = 11'b01000000000,
    StDeg   = 11'b10000000000
  } state_e;

  localparam int AB = g3c_pkg::AddrBits;
  localparam int PB = g3c_pkg::PosBits;

  g3c_pkg::cfg_t cfg;
  state_e state_q, state_d;

  logic [g3c_pkg::PixelBits-1:0] mem [g3c_pkg::StoreDepth];
  logic [g3c_pkg::PixelBits-1:0] rdata_q;
  logic [AB-1:0] raddr;
  logic          wen;

  logic [g3c_pkg::CountBits-1:0] cnt_q;
  logic [15:0] best_q;
  logic [AB-1:0] bidx_q;
  logic [PB-1:0] brow_q, bcol_q, lrow_q, lcol_q;
  logic [2:0] rd_q;
  logic [15:0] nb_q [5];
  logic axis_q;
  logic [15:0] a, b, c;
  logic [g3c_pkg::LogBits-1:0] la, lb, lc;
  logic [g3c_pkg::LogBits-1:0] la_q, lb_q, lc_q;
  logic lda, ldb, ldc, lstart;
  logic dstart, ddone;
  logic [31:0] dnum, dden, dquo;
  logic gauss;
  logic try_g;
  logic [3:0] idx_v;
  g3c_pkg::result_t res_q;
  g3c_pkg::result_t out_q;
  logic out_load;
  logic [10:0] total;
  logic last;
  logic [AB-1:0] nidx;
  logic nvalid;
  logic nvalid_q;
  logic [g3c_pkg::LogBits:0] left, den;
  logic [g3c_pkg::SumBits-1:0] s3, n3;
  logic [31:0] q;

  g3c_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg_o(cfg)
  );
  assign pready = 1'b1;

  assign total = 11'(cfg.rows) * 11'(cfg.cols);
  assign ready_o = (state_q == StLoad);
  assign wen = valid_i && ready_o;
  assign last = (cnt_q + 11'd1) >= total;
  assign out_load = (state_q == StOut) && (!valid_o || ready_i);

  always_comb begin
    nidx = bidx_q;
    nvalid = 1'b1;
    case (rd_q)
      3'd0: nidx = bidx_q;
      3'd1: begin nidx = bidx_q - AB'(1); nvalid = bcol_q != '0; end
      3'd2: begin
        nidx = bidx_q + AB'(1);
        nvalid = (6'(bcol_q) + 6'd1) < 6'(cfg.cols);
      end
      3'd3: begin nidx = bidx_q - AB'(cfg.cols); nvalid = brow_q != '0; end
      3'd4: begin
        nidx = bidx_q + AB'(cfg.cols);
        nvalid = (6'(brow_q) + 6'd1) < 6'(cfg.rows);
      end
      default: ;
    endcase
  end
  assign raddr = nidx;

  always_ff @(posedge clk_i) begin
    if (wen && cnt_q < 11'(g3c_pkg::StoreDepth)) mem[cnt_q[AB-1:0]] <= pixel_value_i;
    rdata_q <= mem[raddr];
  end

  assign a = axis_q ? nb_q[3] : nb_q[1];
  assign c = axis_q ? nb_q[4] : nb_q[2];
  assign b = nb_q[0];

  g3c_log2 u_la (.clk_i, .rst_ni, .start_i(lstart), .x_i(a), .done_o(lda), .log_o(la));
  g3c_log2 u_lb (.clk_i, .rst_ni, .start_i(lstart), .x_i(b), .done_o(ldb), .log_o(lb));
  g3c_log2 u_lc (.clk_i, .rst_ni, .start_i(lstart), .x_i(c), .done_o(ldc), .log_o(lc));

  assign try_g = !((a == b && b == c) || a == '0 || c == '0);
  assign left = {1'b0, lb_q - la_q};
  assign den = left + {1'b0, lb_q - lc_q};
  assign gauss = try_g && (den != '0);
  assign s3 = g3c_pkg::SumBits'(a) + g3c_pkg::SumBits'(b) + g3c_pkg::SumBits'(c);
  assign n3 = g3c_pkg::SumBits'(c) * g3c_pkg::SumBits'(3) + g3c_pkg::SumBits'(b)
              - g3c_pkg::SumBits'(a);
  assign dnum = gauss ? 32'(left[g3c_pkg::LogBits-1:0]) * 32'(cfg.factor)
                      : 32'(n3) * 32'(cfg.factor);
  assign dden = gauss ? 32'(den) : 32'({s3, 1'b0});
  assign q = dquo;
  assign idx_v = (q > 32'(cfg.factor - 5'd1)) ? 4'(cfg.factor - 5'd1) : q[3:0];

  assign lstart = (state_q == StLog);
  assign dstart = (state_q == StDivS);

  g3c_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden), .done_o(ddone), .quo_o(dquo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: if (wen && last) state_d = StRead;
      StRead: if (rd_q == 3'd4) state_d = StCap;
      StCap: state_d = (nb_q[0] == '0 && nb_q[1] == '0 && nb_q[2] == '0 && nb_q[3] == '0
                        && (!nvalid_q || rdata_q == '0)) ? StDeg : StAxis;
      StAxis: state_d = StLog;
      StLog: state_d = StLogW;
      StLogW: if (lda && ldb && ldc) state_d = StDivS;
      StDivS: state_d = StDivW;
      StDivW: if (ddone) state_d = StNext;
      StNext: state_d = axis_q ? StOut : StAxis;
      StOut: if (out_load) state_d = StLoad;
      StDeg: state_d = StOut;
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q <= '0;
      best_q <= '0;
      bidx_q <= '0;
      brow_q <= '0;
      bcol_q <= '0;
      lrow_q <= '0;
      lcol_q <= '0;
      valid_o <= 1'b0;
      rd_q <= '0;
      axis_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) valid_o <= 1'b1;
      else if (ready_i) valid_o <= 1'b0;
      if (wen) begin
        if (pixel_value_i > best_q) begin
          best_q <= pixel_value_i;
          bidx_q <= cnt_q[AB-1:0];
          brow_q <= lrow_q;
          bcol_q <= lcol_q;
        end
        cnt_q <= last ? '0 : cnt_q + 11'd1;
        if (last) begin
          lrow_q <= '0;
          lcol_q <= '0;
        end else if ((6'(lcol_q) + 6'd1) == cfg.cols) begin
          lcol_q <= '0;
          lrow_q <= lrow_q + PB'(1);
        end else begin
          lcol_q <= lcol_q + PB'(1);
        end
      end
      if (state_q == StRead) rd_q <= rd_q + 3'd1;
      if (state_q == StCap) axis_q <= 1'b0;
      if (state_q == StNext) axis_q <= 1'b1;
      if (out_load) begin
        rd_q <= '0;
        best_q <= '0;
        bidx_q <= '0;
        brow_q <= '0;
        bcol_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StRead) begin
      if (rd_q != 3'd0) nb_q[rd_q - 3'd1] <= nvalid_q ? rdata_q : '0;
    end
    if (state_q == StCap) nb_q[4] <= nvalid_q ? rdata_q : '0;
    if (lda) begin
      la_q <= la;
      lb_q <= lb;
      lc_q <= lc;
    end
    if (state_q == StCap) begin
      res_q.row <= brow_q;
      res_q.col <= bcol_q;
    end
    if (state_q == StNext) begin
      if (axis_q) begin
        res_q.sub_row <= idx_v;
        res_q.gauss_row <= gauss;
      end else begin
        res_q.sub_col <= idx_v;
        res_q.gauss_col <= gauss;
      end
      res_q.degenerate <= 1'b0;
    end
    if (state_q == StDeg) begin
      res_q.sub_row <= '0;
      res_q.sub_col <= '0;
      res_q.gauss_row <= 1'b0;
      res_q.gauss_col <= 1'b0;
      res_q.degenerate <= 1'b1;
    end
    if (out_load) out_q <= res_q;
    nvalid_q <= nvalid;
  end

  assign peak_row_o = out_q.row;
  assign peak_col_o = out_q.col;
  assign sub_row_o = out_q.sub_row;
  assign sub_col_o = out_q.sub_col;
  assign row_used_gaussian_o = out_q.gauss_row;
  assign col_used_gaussian_o = out_q.gauss_col;
  assign degenerate_o = out_q.degenerate;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> !ready_o) else $error("item accepted while busy");
  a_out_after_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> ($past(state_q) == StOut))
    else $error("result without finish");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 11'(g3c_pkg::StoreDepth) + 11'd1) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(out_q)))
    else $error("result changed while waiting");
`endif
endmodule
